// ===== design/bdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpt_pkg
// shared widths, reset value, state codes and result type of the button
// debounce and press timer
// ----------------------------------------------------------------------------
package bdpt_pkg;

    localparam int TICK_W = 32;
    localparam int CNT_W  = 8;

    // settle count after reset
    localparam logic [CNT_W-1:0] SETTLE_RESET = 8'd40;

    typedef enum logic [1:0] {
        ST_UP      = 2'd0,
        ST_FALLING = 2'd1,
        ST_DOWN    = 2'd2,
        ST_RISING  = 2'd3
    } t_db_state;

    // result of one update beat, handed from the core to the output register
    typedef struct packed {
        logic              valid;
        logic [TICK_W-1:0] press_duration;
    } t_bdpt_res;

endpackage

// ===== design/bdpt_if.sv =====
// ----------------------------------------------------------------------------
// bdpt interfaces
// valid/ready channels for update beats, result beats and the settle count
// ----------------------------------------------------------------------------
interface bdpt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        pin_level;
    logic [bdpt_pkg::TICK_W-1:0] now_ticks;

    modport source (output valid, output pin_level, output now_ticks, input ready);
    modport sink   (input valid, input pin_level, input now_ticks, output ready);
endinterface

interface bdpt_out_if;
    logic                        valid;
    logic                        ready;
    logic [bdpt_pkg::TICK_W-1:0] press_duration;

    modport source (output valid, output press_duration, input ready);
    modport sink   (input valid, input press_duration, output ready);
endinterface

interface bdpt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bdpt_pkg::CNT_W-1:0] settle_count;

    modport source (output valid, output settle_count, input ready);
    modport sink   (input valid, input settle_count, output ready);
endinterface

// ===== design/bdpt_core.sv =====
// ----------------------------------------------------------------------------
// bdpt_core
// debounce state machine, settle counters and press start capture
// ----------------------------------------------------------------------------
module bdpt_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_pin_level,
    input  logic [bdpt_pkg::TICK_W-1:0] i_now_ticks,
    input  logic [bdpt_pkg::CNT_W-1:0]  i_settle_count,
    output bdpt_pkg::t_bdpt_res         o_res
);
    import bdpt_pkg::*;

    t_db_state         r_state, n_state;
    logic [CNT_W-1:0]  r_fall_cnt, n_fall_cnt;
    logic [CNT_W-1:0]  r_rise_cnt, n_rise_cnt;
    logic [TICK_W-1:0] r_press_start, n_press_start;
    logic              fall_done;
    logic              rise_done;

    assign fall_done = (r_fall_cnt >= i_settle_count);
    assign rise_done = (r_rise_cnt >= i_settle_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_UP;
            r_fall_cnt    <= '0;
            r_rise_cnt    <= '0;
            r_press_start <= '0;
        end else begin
            r_state       <= n_state;
            r_fall_cnt    <= n_fall_cnt;
            r_rise_cnt    <= n_rise_cnt;
            r_press_start <= n_press_start;
        end
    end

    always_comb begin
        n_state              = r_state;
        n_fall_cnt           = r_fall_cnt;
        n_rise_cnt           = r_rise_cnt;
        n_press_start        = r_press_start;
        o_res.valid          = 1'b0;
        o_res.press_duration = i_now_ticks - r_press_start;
        if (i_valid) begin
            case (r_state)
                ST_UP: begin
                    if (!i_pin_level) begin
                        n_state = ST_FALLING;
                    end
                end
                ST_DOWN: begin
                    if (i_pin_level) begin
                        n_state = ST_RISING;
                    end
                end
                ST_FALLING: begin
                    // a decided count restarts at one, not at zero
                    if (fall_done) begin
                        n_fall_cnt = 8'd1;
                        if (!i_pin_level) begin
                            n_state       = ST_DOWN;
                            n_press_start = i_now_ticks;
                        end else begin
                            n_state = ST_UP;
                        end
                    end else begin
                        n_fall_cnt = r_fall_cnt + 8'd1;
                    end
                end
                ST_RISING: begin
                    if (rise_done) begin
                        n_rise_cnt = 8'd1;
                        if (i_pin_level) begin
                            n_state     = ST_UP;
                            o_res.valid = 1'b1;
                        end else begin
                            n_state = ST_DOWN;
                        end
                    end else begin
                        n_rise_cnt = r_rise_cnt + 8'd1;
                    end
                end
                default: begin
                    n_state = ST_UP;
                end
            endcase
        end
    end

    a_res_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (i_valid && r_state == ST_RISING && i_pin_level && rise_done))
        else $error("result outside a confirmed release");

    a_press_to_falling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_state == ST_UP && !i_pin_level) |=> (r_state == ST_FALLING))
        else $error("press level in up did not start falling");

    a_fall_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_state == ST_FALLING)
        |=> (r_fall_cnt == $past(r_fall_cnt) + 8'd1 || r_fall_cnt == 8'd1))
        else $error("fall counter did not step");

    a_press_start_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_state == ST_FALLING && fall_done && !i_pin_level)
        |=> (r_state == ST_DOWN && r_press_start == $past(i_now_ticks)))
        else $error("confirmed press not captured");

endmodule

// ===== design/bdpt_out_reg.sv =====
// ----------------------------------------------------------------------------
// bdpt_out_reg
// result register holding one press duration beat until it is taken
// ----------------------------------------------------------------------------
module bdpt_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  bdpt_pkg::t_bdpt_res         i_res,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [bdpt_pkg::TICK_W-1:0] o_press_duration,
    output logic                        o_free
);
    import bdpt_pkg::*;

    logic              r_valid;
    logic [TICK_W-1:0] r_data;

    // room for a new beat when empty or when the held beat leaves now
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_data <= i_res.press_duration;
        end
    end

    assign o_valid          = r_valid;
    assign o_press_duration = r_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_load)
        else $error("load while a stalled beat is held");

    a_held_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("stalled result beat changed");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_res.valid) |=> r_valid)
        else $error("loaded result not shown");

endmodule

// ===== design/button_debounce_press_timer.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_timer
// Debounces an active-low push button and reports how long each press lasts.
// Every update beat carries the sampled pin level (0 pressed, 1 released) and
// the current tick count. A four-state machine (up, falling, down, rising)
// filters the pin; while falling or rising a settle counter runs, and once it
// has reached the settle count the pin level of that beat decides the edge.
// The counters are not cleared on entering their state. A confirmed press
// stores the tick count; a confirmed release sends one result beat holding
// the press length in ticks, modulo 2^32. The block takes one update beat
// per clock; the beat is handled in the same cycle by the state machine and
// its result lands in a single output register, so an update is accepted
// whenever that register is empty or being emptied, and results appear in
// the cycle after their update. The settle count (reset 40) is written
// through the config channel, which is always ready; write it only while no
// beat is in flight.
// ----------------------------------------------------------------------------
module button_debounce_press_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdpt_in_if.sink    i_in,
    bdpt_cfg_if.sink   i_cfg,
    bdpt_out_if.source o_out
);
    import bdpt_pkg::*;

    logic [CNT_W-1:0] r_settle_count;
    logic             in_accept;
    logic             out_free;
    t_bdpt_res        core_res;

    // settle count register, always open for a write beat
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_count <= SETTLE_RESET;
        end else if (i_cfg.valid) begin
            r_settle_count <= i_cfg.settle_count;
        end
    end

    // an update beat is taken whenever its possible result has a place to go
    assign i_in.ready = out_free;
    assign in_accept  = i_in.valid && out_free;

    // state machine, counters and press start
    bdpt_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_accept),
        .i_pin_level    (i_in.pin_level),
        .i_now_ticks    (i_in.now_ticks),
        .i_settle_count (r_settle_count),
        .o_res          (core_res)
    );

    // result register toward the consumer
    bdpt_out_reg u_out_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (in_accept),
        .i_res            (core_res),
        .i_ready          (o_out.ready),
        .o_valid          (o_out.valid),
        .o_press_duration (o_out.press_duration),
        .o_free           (out_free)
    );

endmodule
